// File: design/lmfs_pkg.sv
// Shared types, constants and helpers for the LED matrix fill and scan block.
package lmfs_pkg;

  // Default panel store dimensions
  localparam int DEF_MAX_COLUMNS = 32;
  localparam int DEF_MAX_ROWS    = 32;

  // Fixed field widths
  localparam int COLOR_W = 24;
  localparam int REG_W   = 6;
  localparam int COORD_W = 7;  // holds a coordinate plus an extent (up to 94)
  localparam int IDX_W   = 2;

  localparam logic [REG_W-1:0] RST_ACTIVE_WIDTH  = REG_W'(32);
  localparam logic [REG_W-1:0] RST_ACTIVE_HEIGHT = REG_W'(32);

  // Channel masks
  localparam logic [COLOR_W-1:0] RED_MASK   = 24'hFF0000;
  localparam logic [COLOR_W-1:0] GREEN_MASK = 24'h00FF00;
  localparam logic [COLOR_W-1:0] BLUE_MASK  = 24'h0000FF;

  typedef enum logic [IDX_W-1:0] {
    REG_ACTIVE_WIDTH  = 2'd0,
    REG_ACTIVE_HEIGHT = 2'd1
  } cfg_reg_t;

  typedef enum logic {
    CMD_FILL = 1'b0,
    CMD_SCAN = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_SCAN_A,
    ST_SCAN_B
  } state_t;

  typedef struct packed {
    logic red;
    logic green;
    logic blue;
  } rgb_t;

  // One bit per channel: set when the channel byte is non-zero
  function automatic rgb_t chan_bits(input logic [COLOR_W-1:0] color);
    rgb_t b;
    b.red   = |(color & RED_MASK);
    b.green = |(color & GREEN_MASK);
    b.blue  = |(color & BLUE_MASK);
    return b;
  endfunction

endpackage

// File: design/led_matrix_fill_and_scan.sv
// Top level: frame buffer fill and split-scan column output for an LED matrix.
// Scan tick: accepted in idle, read through ST_SCAN_A and ST_SCAN_B, then the result strobe.
// Fill: one frame store write per clipped pixel. A new item is taken only back in idle.
// Results are registered and shown for one cycle; the receiver cannot stall.
// Reset: the frame store is cleared one entry a cycle, all MAX_ROWS*MAX_COLUMNS entries,
// with busy high; configuration writes are taken during that pass.
module led_matrix_fill_and_scan #(
  parameter int MAX_COLUMNS = lmfs_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_ROWS    = lmfs_pkg::DEF_MAX_ROWS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // command channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_cmd,
  input  logic [4:0]                   in_rect_x,
  input  logic [4:0]                   in_rect_y,
  input  logic [5:0]                   in_rect_width,
  input  logic [5:0]                   in_rect_height,
  input  logic [lmfs_pkg::COLOR_W-1:0] in_fill_color,
  // result channel
  output logic                         out_strobe,
  output logic                         out_bounds_error,
  output logic                         out_red_top,
  output logic                         out_green_top,
  output logic                         out_blue_top,
  output logic                         out_red_bottom,
  output logic                         out_green_bottom,
  output logic                         out_blue_bottom,
  output logic [3:0]                   out_row_select,
  output logic                         out_latch_pulse,
  output logic                         out_blank,
  // configuration
  input  logic                         cfg_we,
  input  logic [lmfs_pkg::IDX_W-1:0]   cfg_index,
  input  logic [lmfs_pkg::REG_W-1:0]   cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLUMNS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CRD   = lmfs_pkg::COORD_W;

  localparam logic [AW-1:0]  LAST_ENTRY = AW'(DEPTH - 1);
  localparam logic [CRD-1:0] MAX_W      = CRD'(MAX_COLUMNS);
  localparam logic [CRD-1:0] MAX_H      = CRD'(MAX_ROWS);

  // Entry of row r, column c
  function automatic logic [AW-1:0] pix_addr(input logic [CRD-1:0] row,
                                             input logic [CRD-1:0] col);
    return AW'(32'(row) * MAX_COLUMNS + 32'(col));
  endfunction

  lmfs_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]                  clr_r, clr_nxt;
  logic [lmfs_pkg::REG_W-1:0]     act_w_r, act_h_r;
  logic [RW-1:0]                  scan_row_r, scan_row_nxt;
  logic [CW-1:0]                  scan_col_r, scan_col_nxt;

  // fill walk
  logic [CRD-1:0]                 fx_r, fx_nxt, fxe_r, fxe_nxt, fye_r, fye_nxt;
  logic [CRD-1:0]                 fc_r, fc_nxt, fr_r, fr_nxt;
  logic                           fempty_r, fempty_nxt, ferr_r, ferr_nxt;
  logic [lmfs_pkg::COLOR_W-1:0]   fcolor_r, fcolor_nxt;

  lmfs_pkg::rgb_t                 top_r, top_nxt;

  // result register
  logic                           o_strobe_r, o_strobe_nxt;
  logic                           o_err_r, o_err_nxt;
  lmfs_pkg::rgb_t                 o_top_r, o_top_nxt, o_bot_r, o_bot_nxt;
  logic [3:0]                     o_row_r, o_row_nxt;
  logic                           o_latch_r, o_latch_nxt, o_blank_r, o_blank_nxt;

  // frame store ports
  logic                           mem_we;
  logic [AW-1:0]                  mem_waddr, mem_raddr;
  logic [lmfs_pkg::COLOR_W-1:0]   mem_wdata, mem_rdata;

  // used panel size
  logic [CRD-1:0] aw_ext, ah_ext, used_w, used_h, ah_clamp, half;
  logic [CRD-1:0] x_ext, y_ext, x_end, y_end, x_clip, y_clip;
  logic [CRD-1:0] row_use, col_use, row_inc;
  logic           accept, last_col;

  assign aw_ext   = CRD'(act_w_r);
  assign ah_ext   = CRD'(act_h_r);
  assign used_w   = (aw_ext == '0) ? CRD'(1) : ((aw_ext > MAX_W) ? MAX_W : aw_ext);
  assign ah_clamp = (ah_ext < CRD'(2)) ? CRD'(2) : ((ah_ext > MAX_H) ? MAX_H : ah_ext);
  assign used_h   = ah_clamp & ~CRD'(1);
  assign half     = used_h >> 1;

  // rectangle bounds at accept
  assign x_ext  = CRD'(in_rect_x);
  assign y_ext  = CRD'(in_rect_y);
  assign x_end  = x_ext + CRD'(in_rect_width);
  assign y_end  = y_ext + CRD'(in_rect_height);
  assign x_clip = (x_end > used_w) ? used_w : x_end;
  assign y_clip = (y_end > used_h) ? used_h : y_end;

  // scan position, restarted when past the panel
  assign row_use  = (CRD'(scan_row_r) >= half) ? '0 : CRD'(scan_row_r);
  assign col_use  = (CRD'(scan_col_r) >= used_w) ? '0 : CRD'(scan_col_r);
  assign last_col = (CRD'(scan_col_r) + CRD'(1) == used_w);
  assign row_inc  = CRD'(scan_row_r) + CRD'(1);

  assign accept = start && (state_r == lmfs_pkg::ST_IDLE);
  assign busy   = (state_r != lmfs_pkg::ST_IDLE);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_w_r <= lmfs_pkg::RST_ACTIVE_WIDTH;
      act_h_r <= lmfs_pkg::RST_ACTIVE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        lmfs_pkg::REG_ACTIVE_WIDTH:  act_w_r <= cfg_wdata;
        lmfs_pkg::REG_ACTIVE_HEIGHT: act_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= lmfs_pkg::ST_CLEAR;
      clr_r      <= '0;
      scan_row_r <= '0;
      scan_col_r <= '0;
      o_strobe_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_r      <= clr_nxt;
      scan_row_r <= scan_row_nxt;
      scan_col_r <= scan_col_nxt;
      o_strobe_r <= o_strobe_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    fx_r      <= fx_nxt;
    fxe_r     <= fxe_nxt;
    fye_r     <= fye_nxt;
    fc_r      <= fc_nxt;
    fr_r      <= fr_nxt;
    fempty_r  <= fempty_nxt;
    ferr_r    <= ferr_nxt;
    fcolor_r  <= fcolor_nxt;
    top_r     <= top_nxt;
    o_err_r   <= o_err_nxt;
    o_top_r   <= o_top_nxt;
    o_bot_r   <= o_bot_nxt;
    o_row_r   <= o_row_nxt;
    o_latch_r <= o_latch_nxt;
    o_blank_r <= o_blank_nxt;
  end

  // Next state and datapath control
  always_comb begin
    state_nxt    = state_r;
    clr_nxt      = clr_r;
    scan_row_nxt = scan_row_r;
    scan_col_nxt = scan_col_r;
    fx_nxt       = fx_r;
    fxe_nxt      = fxe_r;
    fye_nxt      = fye_r;
    fc_nxt       = fc_r;
    fr_nxt       = fr_r;
    fempty_nxt   = fempty_r;
    ferr_nxt     = ferr_r;
    fcolor_nxt   = fcolor_r;
    top_nxt      = top_r;
    o_strobe_nxt = 1'b0;
    o_err_nxt    = o_err_r;
    o_top_nxt    = o_top_r;
    o_bot_nxt    = o_bot_r;
    o_row_nxt    = o_row_r;
    o_latch_nxt  = o_latch_r;
    o_blank_nxt  = o_blank_r;
    mem_we       = 1'b0;
    mem_waddr    = pix_addr(fr_r, fc_r);
    mem_wdata    = fcolor_r;
    mem_raddr    = '0;

    unique case (state_r)
      // zero the store after reset
      lmfs_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == LAST_ENTRY) begin
          clr_nxt   = '0;
          state_nxt = lmfs_pkg::ST_IDLE;
        end
      end

      lmfs_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_cmd == lmfs_pkg::CMD_FILL) begin
            fx_nxt     = x_ext;
            fxe_nxt    = x_clip;
            fye_nxt    = y_clip;
            fc_nxt     = x_ext;
            fr_nxt     = y_ext;
            fempty_nxt = (x_ext >= x_clip) || (y_ext >= y_clip);
            ferr_nxt   = (x_end > used_w) || (y_end > used_h);
            fcolor_nxt = in_fill_color;
            state_nxt  = lmfs_pkg::ST_FILL;
          end else begin
            // issue the top-half read
            mem_raddr    = pix_addr(row_use, col_use);
            scan_row_nxt = RW'(row_use);
            scan_col_nxt = CW'(col_use);
            state_nxt    = lmfs_pkg::ST_SCAN_A;
          end
        end
      end

      // one pixel a cycle, row by row
      lmfs_pkg::ST_FILL: begin
        if (fempty_r || ((fc_r + CRD'(1) == fxe_r) && (fr_r + CRD'(1) == fye_r))) begin
          mem_we       = !fempty_r;
          o_strobe_nxt = 1'b1;
          o_err_nxt    = ferr_r;
          o_top_nxt    = '0;
          o_bot_nxt    = '0;
          o_row_nxt    = '0;
          o_latch_nxt  = 1'b0;
          o_blank_nxt  = 1'b0;
          state_nxt    = lmfs_pkg::ST_IDLE;
        end else begin
          mem_we = 1'b1;
          if (fc_r + CRD'(1) == fxe_r) begin
            fc_nxt = fx_r;
            fr_nxt = fr_r + CRD'(1);
          end else begin
            fc_nxt = fc_r + CRD'(1);
          end
        end
      end

      // top pixel arrives, bottom read goes out
      lmfs_pkg::ST_SCAN_A: begin
        top_nxt   = lmfs_pkg::chan_bits(mem_rdata);
        mem_raddr = pix_addr(CRD'(scan_row_r) + half, CRD'(scan_col_r));
        state_nxt = lmfs_pkg::ST_SCAN_B;
      end

      // bottom pixel arrives, result out, advance scan position
      lmfs_pkg::ST_SCAN_B: begin
        o_strobe_nxt = 1'b1;
        o_err_nxt    = 1'b0;
        o_top_nxt    = top_r;
        o_bot_nxt    = lmfs_pkg::chan_bits(mem_rdata);
        o_row_nxt    = 4'(scan_row_r);
        o_latch_nxt  = last_col;
        o_blank_nxt  = !last_col;
        if (last_col) begin
          scan_col_nxt = '0;
          scan_row_nxt = (row_inc >= half) ? '0 : RW'(row_inc);
        end else begin
          scan_col_nxt = scan_col_r + CW'(1);
        end
        state_nxt = lmfs_pkg::ST_IDLE;
      end

      default: state_nxt = lmfs_pkg::ST_IDLE;
    endcase
  end

  lmfs_frame_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // Result ports
  assign out_strobe       = o_strobe_r;
  assign out_bounds_error = o_err_r;
  assign out_red_top      = o_top_r.red;
  assign out_green_top    = o_top_r.green;
  assign out_blue_top     = o_top_r.blue;
  assign out_red_bottom   = o_bot_r.red;
  assign out_green_bottom = o_bot_r.green;
  assign out_blue_bottom  = o_bot_r.blue;
  assign out_row_select   = o_row_r;
  assign out_latch_pulse  = o_latch_r;
  assign out_blank        = o_blank_r;

endmodule

// File: design/lmfs_frame_store.sv
// Frame store: one write port and one registered read port.
module lmfs_frame_store #(
  parameter int DEPTH = lmfs_pkg::DEF_MAX_COLUMNS * lmfs_pkg::DEF_MAX_ROWS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [AW-1:0]               wr_addr,
  input  logic [lmfs_pkg::COLOR_W-1:0] wr_data,
  input  logic [AW-1:0]               rd_addr,
  output logic [lmfs_pkg::COLOR_W-1:0] rd_data
);

  logic [lmfs_pkg::COLOR_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/lmfs_checker.sv
// Port-level checks for the LED matrix fill and scan block, bound to the top level.
module lmfs_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic                         in_cmd,
  input logic                         out_strobe,
  input logic                         out_bounds_error,
  input logic                         out_red_top,
  input logic                         out_green_top,
  input logic                         out_blue_top,
  input logic                         out_red_bottom,
  input logic                         out_green_bottom,
  input logic                         out_blue_bottom,
  input logic [3:0]                   out_row_select,
  input logic                         out_latch_pulse,
  input logic                         out_blank
);

  // reset starts the clearing pass, so the block reports busy
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // a scan tick transfer yields its result strobe after ST_SCAN_A and ST_SCAN_B
  a_scan_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_cmd == lmfs_pkg::CMD_SCAN) |-> ##3 out_strobe)
    else $error("scan result missing");

  // an idle block produces no new result
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !busy |=> !out_strobe)
    else $error("result strobe without a pending item");

  // a fill result with a bounds error carries no scan signals
  a_fill_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bounds_error) |-> (!out_latch_pulse && !out_blank &&
      out_row_select == 4'd0 && !out_red_top && !out_green_top && !out_blue_top &&
      !out_red_bottom && !out_green_bottom && !out_blue_bottom))
    else $error("fill result with scan fields set");

endmodule

bind led_matrix_fill_and_scan lmfs_checker u_lmfs_checker (.*);

// File: sim/tb.sv
// Testbench for led_matrix_fill_and_scan: directed and random fill/scan commands checked against a frame model.
`timescale 1ns / 1ps

module tb;
  import lmfs_pkg::*;

  localparam int COLS         = DEF_MAX_COLUMNS;
  localparam int ROWS         = DEF_MAX_ROWS;
  localparam int STORE_DEPTH  = COLS * ROWS;
  localparam int QUIET_LIMIT  = 5000;  // longer than the largest fill or the clear pass
  localparam int MAX_GAP      = 20;
  localparam int DRAIN_LIMIT  = 2000;
  localparam logic [COLOR_W-1:0] WHITE = 24'hFFFFFF;
  // register slots with no register behind them
  localparam logic [IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic       bounds_error;
    rgb_t       top;
    rgb_t       bottom;
    logic [3:0] row_select;
    logic       latch_pulse;
    logic       blank;
  } column_result_t;

  // Frame store model plus the queue of results still to come
  class frame_checker;
    logic [COLOR_W-1:0] pixels [STORE_DEPTH];
    logic [REG_W-1:0]   width_reg;
    logic [REG_W-1:0]   height_reg;
    int unsigned        row_pos;
    int unsigned        col_pos;
    column_result_t     due_results [$];
    int                 errors;

    function new();
      foreach (pixels[k]) pixels[k] = '0;
      width_reg  = RST_ACTIVE_WIDTH;
      height_reg = RST_ACTIVE_HEIGHT;
      row_pos    = 0;
      col_pos    = 0;
      errors     = 0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
      if (idx == REG_ACTIVE_WIDTH) width_reg = val;
      else if (idx == REG_ACTIVE_HEIGHT) height_reg = val;
    endfunction

    function int unsigned eff_width();
      int unsigned w;
      w = width_reg;
      if (w < 1) w = 1;
      if (w > COLS) w = COLS;
      return w;
    endfunction

    // clamp to 2..ROWS, then force even
    function int unsigned eff_height();
      int unsigned h;
      h = height_reg;
      if (h < 2) h = 2;
      if (h > ROWS) h = ROWS;
      return h & ~32'd1;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // Accepted command: update the model and queue its result
    function void note_command(cmd_t cmd, logic [4:0] x, logic [4:0] y, logic [5:0] rw,
                               logic [5:0] rh, logic [COLOR_W-1:0] color);
      column_result_t     r;
      int unsigned        w, h, half, x_end, y_end, i, j;
      logic [COLOR_W-1:0] top_px, bot_px;
      logic               last;
      r = '0;
      w = eff_width();
      h = eff_height();
      if (cmd == CMD_FILL) begin
        x_end = x + rw;
        y_end = y + rh;
        r.bounds_error = (x_end > w) || (y_end > h);
        if (x_end > w) x_end = w;
        if (y_end > h) y_end = h;
        for (i = y; i < y_end; i++)
          for (j = x; j < x_end; j++) pixels[i * COLS + j] = color;
      end else begin
        half = h / 2;
        // scan position may be stale after a register change
        if (row_pos >= half) row_pos = 0;
        if (col_pos >= w) col_pos = 0;
        top_px = pixels[row_pos * COLS + col_pos];
        bot_px = pixels[(row_pos + half) * COLS + col_pos];
        last   = (col_pos + 1 == w);
        r.top.red      = |top_px[23:16];
        r.top.green    = |top_px[15:8];
        r.top.blue     = |top_px[7:0];
        r.bottom.red   = |bot_px[23:16];
        r.bottom.green = |bot_px[15:8];
        r.bottom.blue  = |bot_px[7:0];
        r.row_select   = 4'(row_pos);
        r.latch_pulse  = last;
        r.blank        = !last;
        if (last) begin
          col_pos = 0;
          row_pos++;
          if (row_pos >= half) row_pos = 0;
        end else begin
          col_pos++;
        end
      end
      due_results.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("[%0t] mismatch: %s got %0h want %0h", $time, what, got, want);
      errors++;
    endtask

    task cmp(string what, logic [3:0] got, logic [3:0] want);
      if (got !== want) report(what, got, want);
    endtask

    task check_result(column_result_t got);
      column_result_t want;
      if (due_results.size() == 0) begin
        report("result with nothing outstanding", got, 0);
        return;
      end
      want = due_results.pop_front();
      cmp("bounds_error", got.bounds_error, want.bounds_error);
      cmp("red_top", got.top.red, want.top.red);
      cmp("green_top", got.top.green, want.top.green);
      cmp("blue_top", got.top.blue, want.top.blue);
      cmp("red_bottom", got.bottom.red, want.bottom.red);
      cmp("green_bottom", got.bottom.green, want.bottom.green);
      cmp("blue_bottom", got.bottom.blue, want.bottom.blue);
      cmp("row_select", got.row_select, want.row_select);
      cmp("latch_pulse", got.latch_pulse, want.latch_pulse);
      cmp("blank", got.blank, want.blank);
    endtask
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic                in_cmd;
  logic [4:0]          in_rect_x;
  logic [4:0]          in_rect_y;
  logic [5:0]          in_rect_width;
  logic [5:0]          in_rect_height;
  logic [COLOR_W-1:0]  in_fill_color;
  logic                out_strobe;
  logic                out_bounds_error;
  logic                out_red_top;
  logic                out_green_top;
  logic                out_blue_top;
  logic                out_red_bottom;
  logic                out_green_bottom;
  logic                out_blue_bottom;
  logic [3:0]          out_row_select;
  logic                out_latch_pulse;
  logic                out_blank;
  logic                cfg_we;
  logic [IDX_W-1:0]    cfg_index;
  logic [REG_W-1:0]    cfg_wdata;

  frame_checker sb = new();
  int           quiet_cycles;
  int           drain_cycles;

  led_matrix_fill_and_scan u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_cmd           (in_cmd),
    .in_rect_x        (in_rect_x),
    .in_rect_y        (in_rect_y),
    .in_rect_width    (in_rect_width),
    .in_rect_height   (in_rect_height),
    .in_fill_color    (in_fill_color),
    .out_strobe       (out_strobe),
    .out_bounds_error (out_bounds_error),
    .out_red_top      (out_red_top),
    .out_green_top    (out_green_top),
    .out_blue_top     (out_blue_top),
    .out_red_bottom   (out_red_bottom),
    .out_green_bottom (out_green_bottom),
    .out_blue_bottom  (out_blue_bottom),
    .out_row_select   (out_row_select),
    .out_latch_pulse  (out_latch_pulse),
    .out_blank        (out_blank),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Monitor: check result transfers, then record command transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        sb.check_result({out_bounds_error,
                         out_red_top, out_green_top, out_blue_top,
                         out_red_bottom, out_green_bottom, out_blue_bottom,
                         out_row_select, out_latch_pulse, out_blank});
      if (start && !busy)
        sb.note_command(cmd_t'(in_cmd), in_rect_x, in_rect_y, in_rect_width,
                        in_rect_height, in_fill_color);
    end
  end

  // Watchdog: too long without any transfer ends the run
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || out_strobe) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  // One command transfer, after a random number of idle cycles
  task automatic send_item(cmd_t cmd, logic [4:0] x, logic [4:0] y, logic [5:0] rw,
                           logic [5:0] rh, logic [COLOR_W-1:0] color, int idle_pct);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < idle_pct) gap++;
    repeat (gap) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start          <= 1'b1;
    in_cmd         <= cmd;
    in_rect_x      <= x;
    in_rect_y      <= y;
    in_rect_width  <= rw;
    in_rect_height <= rh;
    in_fill_color  <= color;
    do @(posedge clk); while (busy);
  endtask

  // Scan tick; the rectangle fields are don't-care, so they carry noise
  task automatic send_scan(int idle_pct);
    send_item(CMD_SCAN, 5'($urandom), 5'($urandom), 6'($urandom), 6'($urandom),
              24'($urandom), idle_pct);
  endtask

  // Stop sending and wait until the block has nothing left in flight
  task automatic settle();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small extents; some up to full-size and some past the panel size
  function automatic logic [5:0] pick_extent();
    int r;
    r = $urandom_range(99);
    if (r < 75) return 6'($urandom_range(6));
    if (r < 95) return 6'($urandom_range(32));
    return 6'($urandom_range(63, 33));
  endfunction

  // Fill with the origin usually on the panel; each color byte zero, one bit or random
  task automatic random_fill(int idle_pct);
    int unsigned        w, h;
    logic [4:0]         x, y;
    logic [COLOR_W-1:0] color;
    int                 ch;
    w = sb.eff_width();
    h = sb.eff_height();
    x = ($urandom_range(3) != 0) ? 5'($urandom_range(w - 1)) : 5'($urandom_range(31));
    y = ($urandom_range(3) != 0) ? 5'($urandom_range(h - 1)) : 5'($urandom_range(31));
    for (ch = 0; ch < 3; ch++) begin
      case ($urandom_range(2))
        0: color[ch*8 +: 8] = 8'h00;
        1: color[ch*8 +: 8] = 8'(1 << $urandom_range(7));
        default: color[ch*8 +: 8] = 8'($urandom_range(255));
      endcase
    end
    send_item(CMD_FILL, x, y, pick_extent(), pick_extent(), color, idle_pct);
  endtask

  // Random phase under one panel setting: scan bursts mixed with fills
  task automatic run_phase(logic [REG_W-1:0] w, logic [REG_W-1:0] h, int idle_pct, int n);
    int sent, burst;
    settle();
    write_reg(REG_ACTIVE_WIDTH, w);
    write_reg(REG_ACTIVE_HEIGHT, h);
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(59) == 0) settle();
      if ($urandom_range(99) < 55) begin
        burst = $urandom_range(1, 8);
        repeat (burst) send_scan(idle_pct);
        sent += burst;
      end else begin
        random_fill(idle_pct);
        sent++;
      end
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    start          <= 1'b0;
    in_cmd         <= CMD_FILL;
    in_rect_x      <= '0;
    in_rect_y      <= '0;
    in_rect_width  <= '0;
    in_rect_height <= '0;
    in_fill_color  <= '0;
    cfg_we         <= 1'b0;
    cfg_index      <= REG_ACTIVE_WIDTH;
    cfg_wdata      <= '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // frame store clear pass
    repeat (2) @(posedge clk);
    while (busy) @(posedge clk);

    // Directed: full panel, channel colors, clipping and empty rectangles
    write_reg(REG_ACTIVE_WIDTH, 6'd32);
    write_reg(REG_ACTIVE_HEIGHT, 6'd32);
    send_item(CMD_FILL, 5'd0, 5'd0, 6'd4, 6'd2, RED_MASK, 0);
    send_item(CMD_FILL, 5'd0, 5'd16, 6'd4, 6'd2, GREEN_MASK, 0);
    send_item(CMD_FILL, 5'd2, 5'd0, 6'd2, 6'd1, BLUE_MASK, 0);
    send_item(CMD_FILL, 5'd31, 5'd31, 6'd1, 6'd1, WHITE, 0);        // exact fit at corner
    send_item(CMD_FILL, 5'd31, 5'd0, 6'd32, 6'd1, 24'h010101, 0);   // runs off the right
    send_item(CMD_FILL, 5'd0, 5'd31, 6'd1, 6'd32, 24'h808080, 0);   // runs off the bottom
    send_item(CMD_FILL, 5'd5, 5'd5, 6'd0, 6'd5, WHITE, 0);          // empty, on panel
    send_item(CMD_FILL, 5'd5, 5'd5, 6'd5, 6'd0, WHITE, 0);
    send_item(CMD_FILL, 5'd31, 5'd31, 6'd63, 6'd63, WHITE, 0);      // widest fields
    repeat (6) send_scan(0);

    // Degenerate panel: clamped registers, stale scan position, ignored slots
    settle();
    write_reg(REG_ACTIVE_WIDTH, 6'd0);
    write_reg(REG_ACTIVE_HEIGHT, 6'd0);
    write_reg(REG_SPARE_2, 6'd7);
    write_reg(REG_SPARE_3, 6'd63);
    repeat (3) send_scan(0);
    send_item(CMD_FILL, 5'd20, 5'd0, 6'd0, 6'd1, RED_MASK, 0);      // empty, origin off panel
    send_item(CMD_FILL, 5'd0, 5'd5, 6'd1, 6'd0, GREEN_MASK, 0);
    settle();
    write_reg(REG_ACTIVE_WIDTH, 6'd63);
    write_reg(REG_ACTIVE_HEIGHT, 6'd63);
    repeat (2) send_scan(0);

    // Random phases with sender idling of 0, 66 or 38 percent
    run_phase(6'd32, 6'd32, 0, 76);
    run_phase(6'd8, 6'd6, 66, 76);
    run_phase(6'd1, 6'd1, 0, 76);
    run_phase(6'd63, 6'd63, 38, 76);
    run_phase(6'd13, 6'd17, 66, 76);
    run_phase(6'd20, 6'd3, 38, 76);
    run_phase(6'd3, 6'd2, 0, 76);

    // Drain and finish
    @(negedge clk);
    start <= 1'b0;
    drain_cycles = 0;
    while (sb.pending() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (10) @(posedge clk);
    if (sb.pending() != 0) sb.report("results never delivered", sb.pending(), 0);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
